/* rtl/jkve_pkg.sv */
// ----------------------------------------------------------------------------
// jkve_pkg: shared types and constants of the json key/value extractor
// Parse phases, extraction modes, status codes and the result queue entry.
// ----------------------------------------------------------------------------
package jkve_pkg;

  localparam int KEY_MAX_DEF = 16;

  // result queue: two entries may be written by one document byte
  localparam int FIFO_DEPTH = 4;
  localparam int PTR_W      = 2;
  localparam int CNT_W      = 3;

  typedef enum logic [2:0] {
    PH_SEARCH      = 3'd0,
    PH_AFTER_KEY   = 3'd1,
    PH_AFTER_COLON = 3'd2,
    PH_VALUE       = 3'd3,
    PH_ESCAPE      = 3'd4,
    PH_FOUND       = 3'd5,
    PH_WRONG       = 3'd6,
    PH_ABSENT      = 3'd7
  } phase_t;

  localparam logic [1:0] MODE_STRING  = 2'd0;
  localparam logic [1:0] MODE_INTEGER = 2'd1;
  localparam logic [1:0] MODE_BOOLEAN = 2'd2;
  localparam logic [1:0] MODE_PRESENT = 2'd3;

  localparam logic [1:0] ST_ABSENT = 2'd0;
  localparam logic [1:0] ST_FOUND  = 2'd1;
  localparam logic [1:0] ST_WRONG  = 2'd2;

  localparam logic [1:0] CFG_KEY_LOW  = 2'd0;
  localparam logic [1:0] CFG_KEY_HIGH = 2'd1;
  localparam logic [1:0] CFG_KEY_LEN  = 2'd2;
  localparam logic [1:0] CFG_MODE     = 2'd3;

  localparam logic [1:0] SEEN_NONE  = 2'd0;
  localparam logic [1:0] SEEN_SIGN  = 2'd1;
  localparam logic [1:0] SEEN_DIGIT = 2'd2;

  localparam logic KIND_BYTE   = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_VT     = 8'h0B;
  localparam logic [7:0] CH_FF     = 8'h0C;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_T      = 8'h74;
  localparam logic [7:0] CH_F      = 8'h66;
  localparam logic [7:0] CH_NUL    = 8'h00;

  localparam logic [63:0] MAG_LIMIT = 64'd922337203685477580;
  localparam logic [63:0] I64_MAX   = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] I64_MIN   = 64'h8000_0000_0000_0000;

  typedef struct packed {
    logic [7:0]  value_byte;
    logic        item_kind;
    logic [1:0]  lookup_status;
    logic [63:0] number_value;
    logic        last_item;
  } result_t;

endpackage

/* rtl/json_key_value_extractor.sv */
// ----------------------------------------------------------------------------
// json_key_value_extractor: streaming lookup of one key in a JSON document
// Finds the first quoted key followed by a colon and returns its string
// bytes, integer, boolean or presence, then one status beat per document.
// ----------------------------------------------------------------------------
// One document byte is taken per clock while in_stall is low. The key window
// compare and the phase update finish in the cycle the byte is accepted, and
// the results it causes are written into a four-entry result queue. Most
// bytes cause zero or one result beat; a string byte that is also the
// document's last byte causes two (the value byte, then the status beat), and
// the output drains one beat per cycle while out_stall is low, so in_stall
// rises only while fewer than two queue entries are free. The user writes
// configuration through cfg_* only while the block is idle, which the block does not enforce; cfg_ready is always high.
module json_key_value_extractor
  import jkve_pkg::*;
#(
  parameter int MAX_KEY_BYTES = KEY_MAX_DEF
) (
  input  logic               clk,
  input  logic               rst_n,

  input  logic               in_valid,
  output logic               in_stall,
  input  logic [7:0]         in_doc_byte,
  input  logic               in_doc_end,

  output logic               out_valid,
  input  logic               out_stall,
  output logic [7:0]         out_value_byte,
  output logic               out_item_kind,
  output logic [1:0]         out_lookup_status,
  output logic signed [63:0] out_number_value,
  output logic               out_last_item,

  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [63:0]        cfg_data
);

  localparam int WIN_DEPTH = MAX_KEY_BYTES + 1;
  localparam int FILL_W    = $clog2(MAX_KEY_BYTES + 2);

  // configuration
  logic [63:0] key_low_r, key_high_r;
  logic [4:0]  key_len_r;
  logic [1:0]  mode_r;

  // document state
  phase_t      phase_r, phase_nxt, phase_upd;
  logic [7:0]  win_r [WIN_DEPTH];
  logic [7:0]  win_nxt [WIN_DEPTH];
  logic [7:0]  win_upd [WIN_DEPTH];
  logic [FILL_W-1:0] fill_r, fill_nxt, fill_upd;
  logic [63:0] acc_r, acc_nxt, acc_upd;
  logic        neg_r, neg_nxt, neg_upd;
  logic        ovf_r, ovf_nxt, ovf_upd;
  logic [1:0]  seen_r, seen_nxt, seen_upd;

  // result queue
  result_t          q_r [FIFO_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r, wr_ptr_nxt, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  logic        in_fire, out_fire;
  logic [7:0]  b;
  logic [127:0] key_all;
  logic [FILL_W-1:0] klen;
  logic        key_hit;
  logic        is_digit;
  logic        is_ws_key;
  logic        is_ws_int;
  logic [63:0] acc_x10;
  logic        dig_ovf;
  logic        emit_byte;
  logic        emit_final;
  logic [1:0]  fin_status;
  logic [63:0] fin_number;
  result_t     byte_item, final_item;

  assign cfg_ready = 1'b1;
  assign in_stall  = cnt_r > CNT_W'(FIFO_DEPTH - 2);
  assign out_valid = cnt_r != '0;
  assign in_fire   = in_valid && !in_stall;
  assign out_fire  = out_valid && !out_stall;
  assign b         = in_doc_byte;
  assign key_all   = {key_high_r, key_low_r};

  assign klen = (key_len_r > 5'(MAX_KEY_BYTES)) ? FILL_W'(MAX_KEY_BYTES)
                                                : FILL_W'(key_len_r);

  assign is_digit  = (b >= CH_ZERO) && (b <= CH_NINE);
  assign is_ws_key = (b == CH_SPACE) || (b == CH_TAB) || (b == CH_LF) || (b == CH_CR);
  assign is_ws_int = (b == CH_SPACE) || ((b >= CH_TAB) && (b <= CH_CR));

  // accumulator * 10 + digit, as shifts and adds
  assign acc_x10 = (acc_r << 3) + (acc_r << 1) + {60'd0, b[3:0]};
  assign dig_ovf = (acc_r > MAG_LIMIT) || ((acc_r == MAG_LIMIT) && (b[3:0] > 4'd8));

  // key window compare: lane i holds the i-th most recent byte, which must be
  // key[klen-1-i] for i below klen and the opening quote at i equal to klen
  always_comb begin
    key_hit = (b == CH_QUOTE) && (fill_r >= klen + FILL_W'(1));
    for (int i = 0; i < WIN_DEPTH; i++) begin
      if (i < int'(klen)) begin
        if (win_r[i] != key_all[8*(4'(int'(klen) - 1 - i)) +: 8]) key_hit = 1'b0;
      end else if (i == int'(klen)) begin
        if (win_r[i] != CH_QUOTE) key_hit = 1'b0;
      end
    end
  end

  // per-byte state update
  always_comb begin
    phase_upd = phase_r;
    win_upd   = win_r;
    fill_upd  = fill_r;
    acc_upd   = acc_r;
    neg_upd   = neg_r;
    ovf_upd   = ovf_r;
    seen_upd  = seen_r;
    emit_byte = 1'b0;
    unique case (phase_r)
      PH_SEARCH: begin
        if (b == CH_NUL) begin
          phase_upd = PH_ABSENT;
        end else if (key_hit) begin
          phase_upd = PH_AFTER_KEY;
          for (int i = 0; i < WIN_DEPTH; i++) win_upd[i] = '0;
          fill_upd = '0;
        end else begin
          for (int i = WIN_DEPTH - 1; i > 0; i--) win_upd[i] = win_r[i-1];
          win_upd[0] = b;
          if (fill_r <= FILL_W'(MAX_KEY_BYTES)) fill_upd = fill_r + FILL_W'(1);
        end
      end
      PH_AFTER_KEY: begin
        if (is_ws_key) begin
          phase_upd = PH_AFTER_KEY;
        end else if (b == CH_COLON) begin
          phase_upd = (mode_r == MODE_PRESENT) ? PH_FOUND : PH_AFTER_COLON;
        end else begin
          // restart the search from an empty window at this byte
          for (int i = 0; i < WIN_DEPTH; i++) win_upd[i] = '0;
          if (b == CH_NUL) begin
            phase_upd = PH_ABSENT;
            fill_upd  = '0;
          end else begin
            phase_upd  = PH_SEARCH;
            win_upd[0] = b;
            fill_upd   = FILL_W'(1);
          end
        end
      end
      PH_AFTER_COLON: begin
        unique case (mode_r)
          MODE_PRESENT: phase_upd = PH_FOUND;
          MODE_STRING: begin
            if (b != CH_SPACE) phase_upd = (b == CH_QUOTE) ? PH_VALUE : PH_WRONG;
          end
          MODE_BOOLEAN: begin
            if (b == CH_T) begin
              acc_upd   = 64'd1;
              phase_upd = PH_FOUND;
            end else if (b == CH_F) begin
              acc_upd   = 64'd0;
              phase_upd = PH_FOUND;
            end else if (b != CH_SPACE) begin
              phase_upd = PH_WRONG;
            end
          end
          default: begin
            if (is_ws_int) begin
              phase_upd = PH_AFTER_COLON;
            end else if ((b == CH_PLUS) || (b == CH_MINUS)) begin
              neg_upd   = (b == CH_MINUS);
              seen_upd  = SEEN_SIGN;
              phase_upd = PH_VALUE;
            end else if (is_digit) begin
              seen_upd  = SEEN_DIGIT;
              if (!ovf_r) begin
                if (dig_ovf) ovf_upd = 1'b1;
                else         acc_upd = acc_x10;
              end
              phase_upd = PH_VALUE;
            end else begin
              phase_upd = PH_WRONG;
            end
          end
        endcase
      end
      PH_VALUE: begin
        if (mode_r == MODE_INTEGER) begin
          if (is_digit) begin
            seen_upd = SEEN_DIGIT;
            if (!ovf_r) begin
              if (dig_ovf) ovf_upd = 1'b1;
              else         acc_upd = acc_x10;
            end
          end else begin
            phase_upd = (seen_r == SEEN_DIGIT) ? PH_FOUND : PH_WRONG;
          end
        end else if ((b == CH_NUL) || (b == CH_QUOTE)) begin
          phase_upd = PH_FOUND;
        end else begin
          emit_byte = 1'b1;
          if (b == CH_BSLASH) phase_upd = PH_ESCAPE;
        end
      end
      PH_ESCAPE: begin
        if (b == CH_NUL) begin
          phase_upd = PH_FOUND;
        end else begin
          emit_byte = 1'b1;
          phase_upd = PH_VALUE;
        end
      end
      default: phase_upd = phase_r;
    endcase
  end

  // status beat, taken from the state after this byte
  always_comb begin
    unique case (phase_upd)
      PH_AFTER_COLON: fin_status = (mode_r == MODE_PRESENT) ? ST_FOUND : ST_WRONG;
      PH_VALUE: begin
        if (mode_r == MODE_INTEGER)
          fin_status = (seen_upd == SEEN_DIGIT) ? ST_FOUND : ST_WRONG;
        else
          fin_status = ST_FOUND;
      end
      PH_ESCAPE, PH_FOUND: fin_status = ST_FOUND;
      PH_WRONG:            fin_status = ST_WRONG;
      default:             fin_status = ST_ABSENT;
    endcase
    fin_number = '0;
    if ((fin_status == ST_FOUND) && (mode_r == MODE_INTEGER)) begin
      if (neg_upd)
        fin_number = ovf_upd ? I64_MIN : (64'd0 - acc_upd);
      else
        fin_number = (ovf_upd || (acc_upd > I64_MAX)) ? I64_MAX : acc_upd;
    end else if ((fin_status == ST_FOUND) && (mode_r == MODE_BOOLEAN)) begin
      fin_number = {63'd0, acc_upd[0]};
    end
  end

  assign emit_final = in_doc_end;

  always_comb begin
    byte_item               = '0;
    byte_item.value_byte    = b;
    byte_item.item_kind     = KIND_BYTE;
    final_item              = '0;
    final_item.item_kind    = KIND_STATUS;
    final_item.lookup_status = fin_status;
    final_item.number_value = fin_number;
    final_item.last_item    = 1'b1;
  end

  // document state returns to reset after the last byte
  always_comb begin
    phase_nxt = phase_r;
    win_nxt   = win_r;
    fill_nxt  = fill_r;
    acc_nxt   = acc_r;
    neg_nxt   = neg_r;
    ovf_nxt   = ovf_r;
    seen_nxt  = seen_r;
    if (in_fire) begin
      if (in_doc_end) begin
        phase_nxt = PH_SEARCH;
        for (int i = 0; i < WIN_DEPTH; i++) win_nxt[i] = '0;
        fill_nxt  = '0;
        acc_nxt   = '0;
        neg_nxt   = 1'b0;
        ovf_nxt   = 1'b0;
        seen_nxt  = SEEN_NONE;
      end else begin
        phase_nxt = phase_upd;
        win_nxt   = win_upd;
        fill_nxt  = fill_upd;
        acc_nxt   = acc_upd;
        neg_nxt   = neg_upd;
        ovf_nxt   = ovf_upd;
        seen_nxt  = seen_upd;
      end
    end
  end

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r + PTR_W'(out_fire);
    cnt_nxt    = cnt_r - CNT_W'(out_fire);
    if (in_fire) begin
      wr_ptr_nxt = wr_ptr_r + PTR_W'(emit_byte) + PTR_W'(emit_final);
      cnt_nxt    = cnt_r + CNT_W'(emit_byte) + CNT_W'(emit_final) - CNT_W'(out_fire);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_low_r  <= '0;
      key_high_r <= '0;
      key_len_r  <= '0;
      mode_r     <= MODE_STRING;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_KEY_LOW:  key_low_r  <= cfg_data;
        CFG_KEY_HIGH: key_high_r <= cfg_data;
        CFG_KEY_LEN:  key_len_r  <= cfg_data[4:0];
        CFG_MODE:     mode_r     <= cfg_data[1:0];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_SEARCH;
      for (int i = 0; i < WIN_DEPTH; i++) win_r[i] <= '0;
      fill_r  <= '0;
      acc_r   <= '0;
      neg_r   <= 1'b0;
      ovf_r   <= 1'b0;
      seen_r  <= SEEN_NONE;
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      phase_r <= phase_nxt;
      win_r   <= win_nxt;
      fill_r  <= fill_nxt;
      acc_r   <= acc_nxt;
      neg_r   <= neg_nxt;
      ovf_r   <= ovf_nxt;
      seen_r  <= seen_nxt;
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // queue payload, no reset needed
  always_ff @(posedge clk) begin
    if (in_fire) begin
      if (emit_byte) q_r[wr_ptr_r] <= byte_item;
      if (emit_final) q_r[wr_ptr_r + PTR_W'(emit_byte)] <= final_item;
    end
  end

  assign out_value_byte    = q_r[rd_ptr_r].value_byte;
  assign out_item_kind     = q_r[rd_ptr_r].item_kind;
  assign out_lookup_status = q_r[rd_ptr_r].lookup_status;
  assign out_number_value  = $signed(q_r[rd_ptr_r].number_value);
  assign out_last_item     = q_r[rd_ptr_r].last_item;

  // checks
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(FIFO_DEPTH))
    else $error("result queue count beyond depth");

  a_end_pushes: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && in_doc_end) |=> (cnt_r != '0))
    else $error("last document beat left no status beat queued");

  a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && in_doc_end) |=>
      (phase_r == PH_SEARCH && fill_r == '0 && seen_r == SEEN_NONE && !ovf_r))
    else $error("document state not cleared after last beat");

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= FILL_W'(WIN_DEPTH))
    else $error("key window fill beyond window depth");

  a_last_is_status: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_last_item) |-> (out_item_kind == KIND_STATUS))
    else $error("last beat is not a status beat");

endmodule

/* tb/tb_json_key_value_extractor.sv */
// ----------------------------------------------------------------------------
// tb_json_key_value_extractor: self-checking bench of the json key extractor
// Streams short JSON documents through the block under all four extraction
// modes and several key settings. Each accepted document byte is run
// through a local lookup model. Each result beat is compared field by field
// with the oldest predicted beat. Random stalls fall on both channels.
// ----------------------------------------------------------------------------
module tb_json_key_value_extractor;
  import jkve_pkg::*;

  localparam int DRAIN_CYCLES = 8;
  localparam int LONG_HOLD    = 300;
  localparam int RAND_PHASES  = 12;
  localparam int PHASE_BYTES  = 40;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } doc_beat_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [7:0]         in_doc_byte = 8'h00;
  logic               in_doc_end = 1'b0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [7:0]         out_value_byte;
  logic               out_item_kind;
  logic [1:0]         out_lookup_status;
  logic signed [63:0] out_number_value;
  logic               out_last_item;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [1:0]         cfg_index = 2'd0;
  logic [63:0]        cfg_data = 64'd0;

  json_key_value_extractor dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_doc_byte       (in_doc_byte),
    .in_doc_end        (in_doc_end),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_value_byte    (out_value_byte),
    .out_item_kind     (out_item_kind),
    .out_lookup_status (out_lookup_status),
    .out_number_value  (out_number_value),
    .out_last_item     (out_last_item),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  always #4 clk = ~clk;

  doc_beat_t   doc_beats_q[$];
  result_t     lookup_beats_q[$];
  logic [7:0]  doc_buf[$];
  int          queued_bytes = 0;
  int          fail_count = 0;
  int          src_idle_pct = 14;
  int          sink_idle_pct = 53;
  bit          want_long_hold = 1'b0;
  bit          long_hold_done = 1'b0;
  int          hold_left = 0;

  // register copies on the stimulus side
  logic [63:0] g_lo = '0;
  logic [63:0] g_hi = '0;
  logic [4:0]  g_len = '0;

  // lookup model state and its register copies
  logic [63:0] key_lo_r = '0;
  logic [63:0] key_hi_r = '0;
  logic [4:0]  key_len_r = '0;
  logic [1:0]  mode_r = MODE_STRING;
  logic [7:0]  win [0:16] = '{default: 8'h00};
  int          win_fill = 0;
  phase_t      ph = PH_SEARCH;
  logic [63:0] acc = '0;
  bit          neg = 1'b0;
  bit          ovf = 1'b0;
  logic [1:0]  seen = SEEN_NONE;

  function automatic int used_len(input logic [4:0] len);
    return (len > KEY_MAX_DEF) ? KEY_MAX_DEF : int'(len);
  endfunction

  function automatic logic [7:0] key_byte(input logic [63:0] lo, input logic [63:0] hi,
                                          input int k);
    return (k < 8) ? lo[8*k +: 8] : hi[8*(k-8) +: 8];
  endfunction

  function automatic bit is_digit(input logic [7:0] b);
    return b >= CH_ZERO && b <= CH_NINE;
  endfunction

  function automatic void clear_window();
    for (int j = 0; j <= 16; j++) win[j] = 8'h00;
    win_fill = 0;
  endfunction

  function automatic void clear_doc();
    clear_window();
    ph   = PH_SEARCH;
    acc  = '0;
    neg  = 1'b0;
    ovf  = 1'b0;
    seen = SEEN_NONE;
  endfunction

  function automatic void search_byte(input logic [7:0] b);
    int plen;
    int pos;
    int i;
    bit hit;
    logic [7:0] want;
    plen = used_len(key_len_r) + 2;
    if (b == CH_NUL) begin
      ph = PH_ABSENT;
      return;
    end
    // window holds the newest byte at index 0, so the pattern reads backwards
    hit = (b == CH_QUOTE) && (win_fill + 1 >= plen);
    for (i = 0; hit && i < plen - 1; i++) begin
      pos  = plen - 2 - i;
      want = (pos == 0) ? CH_QUOTE : key_byte(key_lo_r, key_hi_r, pos - 1);
      if (win[i] != want) hit = 1'b0;
    end
    if (hit) begin
      ph = PH_AFTER_KEY;
      clear_window();
      return;
    end
    for (i = 16; i > 0; i--) win[i] = win[i-1];
    win[0] = b;
    if (win_fill <= KEY_MAX_DEF) win_fill++;
  endfunction

  function automatic void add_digit(input logic [7:0] b);
    logic [63:0] d;
    d    = {56'd0, b - CH_ZERO};
    seen = SEEN_DIGIT;
    if (!ovf) begin
      if (acc > MAG_LIMIT || (acc == MAG_LIMIT && d > 64'd8)) ovf = 1'b1;
      else acc = acc * 64'd10 + d;
    end
  endfunction

  function automatic void push_value_byte(input logic [7:0] b);
    result_t r;
    r            = '0;
    r.value_byte = b;
    r.item_kind  = KIND_BYTE;
    lookup_beats_q.push_back(r);
  endfunction

  // advance the lookup by one document byte and queue the beats it causes
  task automatic step_lookup(input logic [7:0] b, input logic e);
    result_t r;
    logic [1:0] md;
    logic [1:0] st;
    md = mode_r;
    case (ph)
      PH_SEARCH: search_byte(b);
      PH_AFTER_KEY: begin
        if (!(b == CH_SPACE || b == CH_TAB || b == CH_LF || b == CH_CR)) begin
          if (b == CH_COLON) begin
            ph = (md == MODE_PRESENT) ? PH_FOUND : PH_AFTER_COLON;
          end else begin
            ph = PH_SEARCH;
            clear_window();
            search_byte(b);
          end
        end
      end
      PH_AFTER_COLON: begin
        if (md == MODE_PRESENT) begin
          ph = PH_FOUND;
        end else if (md == MODE_STRING) begin
          if (b != CH_SPACE) ph = (b == CH_QUOTE) ? PH_VALUE : PH_WRONG;
        end else if (md == MODE_BOOLEAN) begin
          if (b == CH_T) begin
            acc = 64'd1;
            ph  = PH_FOUND;
          end else if (b == CH_F) begin
            acc = 64'd0;
            ph  = PH_FOUND;
          end else if (b != CH_SPACE) begin
            ph = PH_WRONG;
          end
        end else if (!(b == CH_SPACE || (b >= CH_TAB && b <= CH_CR))) begin
          if (b == CH_PLUS || b == CH_MINUS) begin
            neg  = (b == CH_MINUS);
            seen = SEEN_SIGN;
            ph   = PH_VALUE;
          end else if (is_digit(b)) begin
            add_digit(b);
            ph = PH_VALUE;
          end else begin
            ph = PH_WRONG;
          end
        end
      end
      PH_VALUE: begin
        if (md == MODE_INTEGER) begin
          if (is_digit(b)) add_digit(b);
          else ph = (seen == SEEN_DIGIT) ? PH_FOUND : PH_WRONG;
        end else if (b == CH_NUL || b == CH_QUOTE) begin
          ph = PH_FOUND;
        end else begin
          push_value_byte(b);
          if (b == CH_BSLASH) ph = PH_ESCAPE;
        end
      end
      PH_ESCAPE: begin
        if (b == CH_NUL) begin
          ph = PH_FOUND;
        end else begin
          push_value_byte(b);
          ph = PH_VALUE;
        end
      end
      default: ;
    endcase

    if (e) begin
      r = '0;
      case (ph)
        PH_AFTER_COLON:     st = (md == MODE_PRESENT) ? ST_FOUND : ST_WRONG;
        PH_VALUE:           st = (md != MODE_INTEGER || seen == SEEN_DIGIT) ? ST_FOUND : ST_WRONG;
        PH_ESCAPE, PH_FOUND: st = ST_FOUND;
        PH_WRONG:           st = ST_WRONG;
        default:            st = ST_ABSENT;
      endcase
      if (st == ST_FOUND && md == MODE_INTEGER) begin
        if (neg) r.number_value = ovf ? I64_MIN : (64'd0 - acc);
        else r.number_value = (ovf || acc > I64_MAX) ? I64_MAX : acc;
      end else if (st == ST_FOUND && md == MODE_BOOLEAN) begin
        r.number_value = {63'd0, acc[0]};
      end
      r.item_kind     = KIND_STATUS;
      r.lookup_status = st;
      r.last_item     = 1'b1;
      lookup_beats_q.push_back(r);
      clear_doc();
    end
  endtask

  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
      fail_count++;
    end
  endtask

  // document byte driver
  always @(posedge clk) begin : drive_doc
    doc_beat_t beat;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || !in_stall) begin
      if (doc_beats_q.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
        beat = doc_beats_q.pop_front();
        in_valid    <= 1'b1;
        in_doc_byte <= beat.data;
        in_doc_end  <= beat.last;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // result stall, with one long hold-off to back the block up
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (want_long_hold && !long_hold_done) begin
      out_stall      <= 1'b1;
      hold_left      <= LONG_HOLD;
      long_hold_done <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < sink_idle_pct);
    end
  end

  // predict on accepted beats, then check the result beat of this edge
  always @(posedge clk) begin : watch_lookup
    result_t want;
    if (rst_n) begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_KEY_LOW:  key_lo_r  = cfg_data;
          CFG_KEY_HIGH: key_hi_r  = cfg_data;
          CFG_KEY_LEN:  key_len_r = cfg_data[4:0];
          default:      mode_r    = cfg_data[1:0];
        endcase
      end
      if (in_valid && !in_stall) step_lookup(in_doc_byte, in_doc_end);
      if (out_valid && !out_stall) begin
        if (lookup_beats_q.size() == 0) begin
          $display("%0t: result beat with nothing expected, got kind %0b status %0d byte %0h",
                   $time, out_item_kind, out_lookup_status, out_value_byte);
          fail_count++;
        end else begin
          want = lookup_beats_q.pop_front();
          check_field("value_byte", want.value_byte, out_value_byte);
          check_field("item_kind", want.item_kind, out_item_kind);
          check_field("lookup_status", want.lookup_status, out_lookup_status);
          check_field("number_value", want.number_value, out_number_value);
          check_field("last_item", want.last_item, out_last_item);
        end
      end
    end
  end

  task automatic write_reg(input logic [1:0] idx, input logic [63:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic set_config(input logic [63:0] lo, input logic [63:0] hi,
                            input logic [4:0] len, input logic [1:0] md);
    g_lo   = lo;
    g_hi   = hi;
    g_len  = len;
    write_reg(CFG_KEY_LOW, lo);
    write_reg(CFG_KEY_HIGH, hi);
    write_reg(CFG_KEY_LEN, {59'd0, len});
    write_reg(CFG_MODE, {62'd0, md});
    cfg_valid <= 1'b0;
  endtask

  task automatic wait_for_idle();
    while (doc_beats_q.size() != 0 || in_valid || lookup_beats_q.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic void pack_key(input string s, output logic [63:0] lo,
                                   output logic [63:0] hi);
    logic [127:0] k;
    k = '0;
    for (int i = 0; i < 16 && i < s.len(); i++) k[8*i +: 8] = s[i];
    lo = k[63:0];
    hi = k[127:64];
  endfunction

  task automatic add_text(input string s);
    for (int i = 0; i < s.len(); i++) doc_buf.push_back(s[i]);
  endtask

  task automatic add_key();
    doc_buf.push_back(CH_QUOTE);
    for (int i = 0; i < used_len(g_len); i++) doc_buf.push_back(key_byte(g_lo, g_hi, i));
    doc_buf.push_back(CH_QUOTE);
  endtask

  task automatic add_ws(input bit all_six);
    logic [7:0] c;
    repeat ($urandom_range(0, 2)) begin
      case ($urandom_range(all_six ? 5 : 3))
        0:       c = CH_SPACE;
        1:       c = CH_TAB;
        2:       c = CH_LF;
        3:       c = CH_CR;
        4:       c = CH_VT;
        default: c = CH_FF;
      endcase
      doc_buf.push_back(c);
    end
  endtask

  // mostly printable, some high bytes, escapes and the odd zero byte
  function automatic logic [7:0] text_byte();
    int r;
    r = $urandom_range(39);
    if (r == 0) return CH_NUL;
    if (r < 3) return 8'h80 + 8'($urandom_range(127));
    if (r < 5) return CH_BSLASH;
    return 8'($urandom_range(8'h20, 8'h7E));
  endfunction

  task automatic add_value(input logic [1:0] md);
    int r;
    logic [7:0] c;
    r = $urandom_range(9);
    case (md)
      MODE_INTEGER: begin
        if (r == 0) begin
          case ($urandom_range(3))
            0:       add_text("9223372036854775807");
            1:       add_text("-9223372036854775808");
            2:       add_text("9223372036854775808");
            default: add_text("-92233720368547758070");
          endcase
        end else if (r == 1) begin
          add_text(($urandom_range(1) == 0) ? "-" : "x");
        end else begin
          if ($urandom_range(2) == 0) doc_buf.push_back($urandom_range(1) ? CH_PLUS : CH_MINUS);
          repeat ((r == 2) ? $urandom_range(19, 24) : $urandom_range(1, 6)) begin
            c = CH_ZERO + 8'($urandom_range(9));
            doc_buf.push_back(c);
          end
        end
      end
      MODE_BOOLEAN: begin
        if (r < 4) add_text("true");
        else if (r < 8) add_text("false");
        else add_text("nul");
      end
      default: begin
        if (r == 0) begin
          add_text("42");
        end else begin
          doc_buf.push_back(CH_QUOTE);
          repeat ($urandom_range(0, 8)) begin
            c = text_byte();
            doc_buf.push_back(c);
            if (c == CH_BSLASH) begin
              c = ($urandom_range(1) == 0) ? CH_QUOTE : 8'($urandom_range(255));
              doc_buf.push_back(c);
            end
          end
          // r == 1 leaves the string open
          if (r != 1) doc_buf.push_back(CH_QUOTE);
        end
      end
    endcase
  endtask

  task automatic flush_doc(input bit ends_doc);
    doc_beat_t beat;
    for (int i = 0; i < doc_buf.size(); i++) begin
      beat.data = doc_buf[i];
      beat.last = ends_doc && (i == doc_buf.size() - 1);
      doc_beats_q.push_back(beat);
    end
    queued_bytes += doc_buf.size();
    doc_buf.delete();
  endtask

  task automatic build_random_doc(input logic [1:0] md);
    int shape;
    int cut;
    logic [7:0] c;
    shape = $urandom_range(9);
    if (shape < 2) begin
      repeat ($urandom_range(1, 10)) begin
        c = 8'($urandom_range(255));
        doc_buf.push_back(c);
      end
    end else begin
      if ($urandom_range(2) == 0) add_text("{\"q\":1,");
      if ($urandom_range(3) == 0) begin
        // key that is not followed by a colon
        add_key();
        add_ws(1'b0);
        doc_buf.push_back(($urandom_range(1) == 0) ? CH_QUOTE : 8'h2C);
      end
      add_key();
      add_ws(1'b0);
      doc_buf.push_back(CH_COLON);
      if (md == MODE_INTEGER) add_ws(1'b1);
      else if ($urandom_range(7) == 0) add_ws(1'b0);
      else if ($urandom_range(1) == 0) doc_buf.push_back(CH_SPACE);
      add_value(md);
      if ($urandom_range(1) == 0) add_text("}");
      if (shape == 2) begin
        cut = $urandom_range(1, doc_buf.size());
        while (doc_buf.size() > cut) doc_buf.delete(doc_buf.size() - 1);
      end else if (shape == 3) begin
        c = 8'($urandom_range(255));
        doc_buf[$urandom_range(doc_buf.size() - 1)] = c;
      end
    end
    flush_doc(1'b1);
  endtask

  initial begin : run_lookup
    logic [63:0] lo;
    logic [63:0] hi;
    logic [4:0]  len;
    logic [1:0]  md;
    int          p;
    int          kind;
    int          target;
    string       letters;

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // reset settings: empty key, string mode, escaped quote in the value
    add_text("{\"\":\"a\\\"b\"}");
    flush_doc(1'b1);
    add_text("x");
    flush_doc(1'b1);
    wait_for_idle();

    // integer: vertical tab before the number, saturation, search restart
    pack_key("k", lo, hi);
    set_config(lo, '1, 5'd1, MODE_INTEGER);
    add_text("\"k\" :");
    doc_buf.push_back(CH_VT);
    add_text("-9223372036854775809,");
    flush_doc(1'b1);
    add_text("\"k\":9223372036854775807");
    flush_doc(1'b1);
    add_text("\"k\"x\"k\":+");
    flush_doc(1'b1);
    wait_for_idle();

    // boolean, key length beyond the maximum, quote inside the key
    pack_key("a\"bcdefghijklmno", lo, hi);
    set_config(lo, hi, 5'd31, MODE_BOOLEAN);
    add_text("\"a\"bcdefghijklmno\": t");
    flush_doc(1'b1);
    add_text("\"a\"bcdefghijklmno\":n");
    flush_doc(1'b1);
    wait_for_idle();

    // presence only, zero byte ending the text early
    pack_key("k", lo, hi);
    set_config(lo, hi, 5'd1, MODE_PRESENT);
    add_text("\"k\":");
    flush_doc(1'b1);
    doc_buf.push_back(CH_NUL);
    add_text("\"k\":");
    flush_doc(1'b1);
    wait_for_idle();

    // string: high byte, zero byte closing the value, mode switch mid-value
    set_config(lo, hi, 5'd1, MODE_STRING);
    add_text("\"k\":\"x");
    doc_buf.push_back(8'hFF);
    doc_buf.push_back(CH_NUL);
    add_text("y\"");
    flush_doc(1'b1);
    add_text("\"k\":\"ab");
    flush_doc(1'b0);
    wait_for_idle();
    set_config(lo, hi, 5'd1, MODE_BOOLEAN);
    add_text("c");
    flush_doc(1'b1);

    for (p = 0; p < RAND_PHASES; p++) begin
      if (p == RAND_PHASES / 3) begin
        src_idle_pct  = 53;
        sink_idle_pct = 14;
      end else if (p == 2 * RAND_PHASES / 3) begin
        src_idle_pct  = 0;
        sink_idle_pct = 0;
      end
      wait_for_idle();
      kind = (p < 4) ? p : $urandom_range(4, 9);
      letters = "";
      for (int i = 0; i < 16; i++) letters = {letters, string'(8'h61 + 8'($urandom_range(25)))};
      pack_key(letters, lo, hi);
      case (kind)
        0: begin
          lo  = {$urandom, $urandom};
          hi  = {$urandom, $urandom};
          len = 5'd0;
        end
        1: begin
          lo  = '1;
          hi  = '1;
          len = 5'd16;
        end
        2: len = 5'($urandom_range(17, 31));
        3: begin
          lo  = {$urandom, $urandom};
          hi  = {$urandom, $urandom};
          len = 5'($urandom_range(1, 16));
        end
        default: begin
          hi  = {$urandom, $urandom};
          len = 5'($urandom_range(1, 8));
        end
      endcase
      md = 2'(p % 4);
      set_config(lo, hi, len, md);
      target = queued_bytes + PHASE_BYTES;
      while (queued_bytes < target) build_random_doc(md);
      // sender keeps offering while the result side is held off
      if (p == 2 * RAND_PHASES / 3) want_long_hold = 1'b1;
    end

    wait_for_idle();
    if (fail_count == 0 && lookup_beats_q.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #3000000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
